/* rtl/rthw_pkg.sv */
// Shared constants, types and register codes for the rolling triple hash window.
// No dependencies; every other file imports this package.
package rthw_pkg;

  // Ring of recent bytes and byte counter
  localparam int WINDOW_MAX = 256;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 9;
  localparam int HASH_W     = 30;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 30;
  localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Modular arithmetic: three lanes, one per modulus
  localparam int NUM_LANES = 3;
  localparam int BASE_W    = 9;
  localparam int PROD_W    = 39;
  localparam int QUO_W     = 10;
  localparam int RCP_SH    = 16;
  localparam int QP_W      = QUO_W + RCP_SH;
  localparam int RD_W      = 32;
  localparam int REM_W     = 31;

  localparam logic [HASH_W-1:0] LANE_MOD [NUM_LANES] =
    '{30'd1000000007, 30'd1000000033, 30'd1000000009};
  localparam logic [BASE_W-1:0] LANE_BASE [NUM_LANES] = '{9'd263, 9'd269, 9'd271};

  // floor(2^(PROD_W-QUO_W+RCP_SH) / m): quotient estimate is low by at most one
  localparam longint RCP_NUM = 64'd1 << (PROD_W - QUO_W + RCP_SH);
  localparam logic [RCP_SH-1:0] LANE_RCP [NUM_LANES] = '{
    RCP_SH'(RCP_NUM / 64'd1000000007),
    RCP_SH'(RCP_NUM / 64'd1000000033),
    RCP_SH'(RCP_NUM / 64'd1000000009)
  };

  // Queue between front and back
  localparam int QPTR_W = 2;
  localparam int QDEPTH = 1 << QPTR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN,
    REG_TOP_POWER_A,
    REG_TOP_POWER_B,
    REG_TOP_POWER_C
  } cfg_reg_t;

  // One classified byte, ready for the arithmetic
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic [BYTE_W-1:0] old_byte;
    logic              restart;
    logic              remove;
    logic              emit;
  } work_t;

endpackage

/* rtl/rthw_ifs.sv */
// Valid/ready channel interfaces: input bytes, output hashes, configuration writes.
// Depends on rthw_pkg.
interface rthw_item_if import rthw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              restart;
  modport source (output valid, in_byte, restart, input ready);
  modport sink   (input valid, in_byte, restart, output ready);
endinterface

interface rthw_hash_if import rthw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_a;
  logic [HASH_W-1:0] hash_b;
  logic [HASH_W-1:0] hash_c;
  modport source (output valid, hash_a, hash_b, hash_c, input ready);
  modport sink   (input valid, hash_a, hash_b, hash_c, output ready);
endinterface

interface rthw_cfg_if import rthw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rthw_front.sv */
// Front end: accepts bytes, keeps the ring of recent bytes and the fill count,
// classifies each byte and hands it on. Depends on rthw_pkg and rthw_ifs.
module rthw_front import rthw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rthw_item_if.sink  item,
  input  logic [LEN_W-1:0] window_len,
  output logic       push_valid,
  input  logic       push_ready,
  output work_t      push_item
);

  logic [BYTE_W-1:0] ring [WINDOW_MAX];
  logic [PTR_W-1:0]  wr_pos;
  logic [PTR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  seen;
  logic [CNT_W-1:0]  seen_eff;
  logic [CNT_W-1:0]  seen_next;
  logic [CNT_W-1:0]  len_cnt;
  logic [CMP_W-1:0]  len_eff;
  logic              accept;
  logic              remove;
  logic              emit;

  logic              stg_valid;
  logic [BYTE_W-1:0] stg_byte;
  logic [BYTE_W-1:0] old_q;
  logic              stg_restart;
  logic              stg_remove;
  logic              stg_emit;

  // Clamp the window length into 1..WINDOW_MAX
  always_comb begin
    if (window_len == '0) begin
      len_eff = CMP_W'(1);
    end else if (CMP_W'(window_len) > CMP_W'(WINDOW_MAX)) begin
      len_eff = CMP_W'(WINDOW_MAX);
    end else begin
      len_eff = CMP_W'(window_len);
    end
  end

  assign len_cnt   = CNT_W'(len_eff);
  assign seen_eff  = item.restart ? '0 : seen;
  assign remove    = CMP_W'(seen_eff) >= len_eff;
  assign seen_next = (seen_eff == CNT_W'(WINDOW_MAX)) ? seen_eff : seen_eff + 1'b1;
  assign emit      = CMP_W'(seen_next) >= len_eff;

  // Address of the byte leaving the window
  always_comb begin
    if (CNT_W'(wr_pos) >= len_cnt) begin
      rd_addr = PTR_W'(CNT_W'(wr_pos) - len_cnt);
    end else begin
      rd_addr = PTR_W'(CNT_W'(wr_pos) + CNT_W'(WINDOW_MAX) - len_cnt);
    end
  end

  assign item.ready = !stg_valid || push_ready;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      wr_pos    <= '0;
      seen      <= '0;
    end else begin
      if (accept) begin
        stg_valid <= 1'b1;
        seen      <= seen_next;
        wr_pos    <= (wr_pos == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_pos + 1'b1;
      end else if (push_ready) begin
        stg_valid <= 1'b0;
      end
    end
  end

  // Ring and stage payload; read before write when both hit one entry
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wr_pos] <= item.in_byte;
      old_q        <= ring[rd_addr];
      stg_byte     <= item.in_byte;
      stg_restart  <= item.restart;
      stg_remove   <= remove;
      stg_emit     <= emit;
    end
  end

  assign push_valid = stg_valid;

  always_comb begin
    push_item.in_byte  = stg_byte;
    push_item.old_byte = old_q;
    push_item.restart  = stg_restart;
    push_item.remove   = stg_remove;
    push_item.emit     = stg_emit;
  end

endmodule

/* rtl/rthw_fifo.sv */
// Short queue of classified bytes between front and back end.
// Depends on rthw_pkg.
module rthw_fifo import rthw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_item
);

  work_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = count != (QPTR_W + 1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/rthw_back.sv */
// Back end: three modular hash lanes driven by one sequencer, plus the output register.
// Depends on rthw_pkg and rthw_ifs.
module rthw_back import rthw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  work_t             pop_item,
  input  logic [HASH_W-1:0] top_power_a,
  input  logic [HASH_W-1:0] top_power_b,
  input  logic [HASH_W-1:0] top_power_c,
  rthw_hash_if.source       hashes
);

  typedef enum logic [1:0] {ST_IDLE, ST_QUO, ST_REM, ST_FIX} state_t;

  state_t            state;
  logic              phase;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_emit;
  logic              out_valid;
  logic              out_free;
  logic              finish;

  logic [HASH_W-1:0] acc      [NUM_LANES];
  logic [HASH_W-1:0] acc_eff  [NUM_LANES];
  logic [HASH_W-1:0] pw       [NUM_LANES];
  logic [HASH_W-1:0] pw_red   [NUM_LANES];
  logic [HASH_W-1:0] negpw    [NUM_LANES];
  logic [HASH_W-1:0] fixed    [NUM_LANES];
  logic [HASH_W-1:0] out_hash [NUM_LANES];
  logic [PROD_W-1:0] x        [NUM_LANES];
  logic [PROD_W-1:0] x_first  [NUM_LANES];
  logic [PROD_W-1:0] x_direct [NUM_LANES];
  logic [PROD_W-1:0] x_shift  [NUM_LANES];
  logic [QP_W-1:0]   qprod    [NUM_LANES];
  logic [QUO_W-1:0]  qe       [NUM_LANES];
  logic [RD_W-1:0]   rdiff    [NUM_LANES];
  logic [REM_W-1:0]  r        [NUM_LANES];

  assign pw[0] = top_power_a;
  assign pw[1] = top_power_b;
  assign pw[2] = top_power_c;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      pw_red[l]   = (pw[l] >= LANE_MOD[l]) ? pw[l] - LANE_MOD[l] : pw[l];
      acc_eff[l]  = pop_item.restart ? '0 : acc[l];
      // Removal: h + old * (m - pw) is congruent to h - old * pw
      x_first[l]  = PROD_W'(acc_eff[l])
                  + PROD_W'(pop_item.old_byte) * PROD_W'(negpw[l]);
      x_direct[l] = PROD_W'(acc_eff[l]) * PROD_W'(LANE_BASE[l])
                  + PROD_W'(pop_item.in_byte);
      // Quotient estimate from the top bits, then exact remainder below 2m
      qprod[l]    = QP_W'(x[l][PROD_W-1 -: QUO_W]) * QP_W'(LANE_RCP[l]);
      rdiff[l]    = x[l][RD_W-1:0] - RD_W'(PROD_W'(qe[l]) * PROD_W'(LANE_MOD[l]));
      fixed[l]    = (r[l] >= REM_W'(LANE_MOD[l])) ? HASH_W'(r[l] - REM_W'(LANE_MOD[l]))
                                                  : HASH_W'(r[l]);
      x_shift[l]  = PROD_W'(fixed[l]) * PROD_W'(LANE_BASE[l]) + PROD_W'(cur_byte);
    end
  end

  // Negated top power, refreshed every cycle from the static config
  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      negpw[l] <= (pw_red[l] == '0) ? '0 : LANE_MOD[l] - pw_red[l];
    end
  end

  assign pop_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || hashes.ready;
  assign finish    = (state == ST_FIX) && phase && (!cur_emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
        acc[l] <= '0;
      end
    end else begin
      if (finish && cur_emit) begin
        out_valid <= 1'b1;
      end else if (hashes.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            phase    <= !pop_item.remove;
            cur_byte <= pop_item.in_byte;
            cur_emit <= pop_item.emit;
            for (int l = 0; l < NUM_LANES; l++) begin
              x[l] <= pop_item.remove ? x_first[l] : x_direct[l];
            end
            state <= ST_QUO;
          end
        end
        ST_QUO: begin
          for (int l = 0; l < NUM_LANES; l++) begin
            qe[l] <= qprod[l][QP_W-1 -: QUO_W];
          end
          state <= ST_REM;
        end
        ST_REM: begin
          for (int l = 0; l < NUM_LANES; l++) begin
            r[l] <= rdiff[l][REM_W-1:0];
          end
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (!phase) begin
            phase <= 1'b1;
            for (int l = 0; l < NUM_LANES; l++) begin
              x[l] <= x_shift[l];
            end
            state <= ST_QUO;
          end else if (finish) begin
            for (int l = 0; l < NUM_LANES; l++) begin
              acc[l] <= fixed[l];
            end
            // Hold a waiting result; load only when this byte makes one
            if (cur_emit) begin
              for (int l = 0; l < NUM_LANES; l++) begin
                out_hash[l] <= fixed[l];
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign hashes.valid  = out_valid;
  assign hashes.hash_a = out_hash[0];
  assign hashes.hash_b = out_hash[1];
  assign hashes.hash_c = out_hash[2];

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    acc[0] < LANE_MOD[0] && acc[1] < LANE_MOD[1] && acc[2] < LANE_MOD[2])
    else $error("hash accumulator not reduced");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_REM |=> (r[0] < (REM_W'(LANE_MOD[0]) << 1)) &&
                        (r[1] < (REM_W'(LANE_MOD[1]) << 1)) &&
                        (r[2] < (REM_W'(LANE_MOD[2]) << 1)))
    else $error("quotient estimate off by more than one");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIX && phase && cur_emit))
    else $error("result raised outside final step");

endmodule

/* rtl/rolling_triple_hash_window_unit.sv */
// Top level of the rolling triple hash window: config registers, front end,
// queue and back end. Depends on rthw_pkg, rthw_ifs, rthw_front, rthw_fifo, rthw_back.
//
//   channel  role    payload                       transaction
//   item     sink    in_byte[7:0], restart         valid && ready
//   hashes   source  hash_a, hash_b, hash_c [29:0] valid && ready
//   cfg      sink    index[3:0], data[29:0]        valid && ready (ready held high)
//
// Sequence: the back end runs one shared quotient / remainder / fix sequence per
// reduction and needs two reductions when a byte leaves the window; it takes no
// new byte from the queue until it is through with the last one.
// Path: each byte passes the staging register and the queue before the back end,
// which holds its result in the output register.
// Reset: synchronous; the byte ring is not cleared, so no clearing pass.
// Stalls: the queue lets the front keep taking bytes while the back end works or
// the output register waits; a held result stalls the back end first, and the
// front once the queue and the staging register are full.
module rolling_triple_hash_window_unit import rthw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rthw_item_if.sink   item,
  rthw_hash_if.source hashes,
  rthw_cfg_if.sink    cfg
);

  logic [LEN_W-1:0]  window_len;
  logic [HASH_W-1:0] top_power_a;
  logic [HASH_W-1:0] top_power_b;
  logic [HASH_W-1:0] top_power_c;

  logic  push_valid;
  logic  push_ready;
  work_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_item;

  // Accept writes every cycle; drop writes to unknown indexes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len  <= LEN_W'(1);
      top_power_a <= HASH_W'(1);
      top_power_b <= HASH_W'(1);
      top_power_c <= HASH_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_WINDOW_LEN:  window_len  <= cfg.data[LEN_W-1:0];
        REG_TOP_POWER_A: top_power_a <= cfg.data[HASH_W-1:0];
        REG_TOP_POWER_B: top_power_b <= cfg.data[HASH_W-1:0];
        REG_TOP_POWER_C: top_power_c <= cfg.data[HASH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify each byte and fetch the byte leaving the window
  rthw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .window_len (window_len),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Decouple the front from the arithmetic
  rthw_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Advance the three hashes and hold the result for the sink
  rthw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .top_power_a (top_power_a),
    .top_power_b (top_power_b),
    .top_power_c (top_power_c),
    .hashes      (hashes)
  );

endmodule

/* bench/rolling_triple_hash_window_unit_test.sv */
// Self-checking bench for rolling_triple_hash_window_unit: a directed table, then random
// strings under many settings, checked against an in-bench window hash model or table triples.
// Depends on rthw_pkg, the rthw interfaces and the unit itself.
module rolling_triple_hash_window_unit_test;
  import rthw_pkg::*;

  // Run shape
  localparam int RAND_BYTES    = 1700;
  localparam int SETTLE_CYCLES = 40;      // enough to empty a full queue of four bytes, plus staging
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_REPORTS   = 10;

  // Lane constants of the three hashes: a, b, c
  localparam longint unsigned HASH_MOD [3]  = '{64'd1000000007, 64'd1000000033, 64'd1000000009};
  localparam longint unsigned HASH_BASE [3] = '{64'd263, 64'd269, 64'd271};

  typedef logic [2:0][HASH_W-1:0] hash_trio_t;   // [0] = hash_a, [1] = hash_b, [2] = hash_c

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One line of the directed table: a register write or one byte, with an optional
  // hand-written hash triple
  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [BYTE_W-1:0]     data_byte;
    logic                  restart;
    logic                  known;
    hash_trio_t            known_hash;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rthw_item_if item_ch ();
  rthw_hash_if hash_ch ();
  rthw_cfg_if  cfg_ch ();

  rolling_triple_hash_window_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .hashes (hash_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow registers and window state of the hash model
  logic [LEN_W-1:0]  win_len_q;
  logic [HASH_W-1:0] top_pow [3];
  longint unsigned   acc [3];
  logic [BYTE_W-1:0] byte_ring [WINDOW_MAX];
  int                bytes_seen;
  int                ring_wr;

  hash_trio_t awaited_hashes [$];
  stim_row_t  plan [$];

  int  failures;
  int  cycles;
  int  bytes_sent;
  int  rand_bytes;
  int  hashes_checked;
  int  reg_writes;
  int  phases;
  int  widest_window;
  bit  tx_gaps;
  bit  rx_stalls;
  bit  streaming;

  // Advance the three window hashes by one byte; return 1 when the window is full
  function automatic bit advance_window_hash(input logic [BYTE_W-1:0] b, input logic r,
                                             output hash_trio_t h);
    int              len;
    longint unsigned leaving;
    longint unsigned t;
    len = int'(win_len_q);
    if (len < 1) len = 1;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    if (r) begin
      acc        = '{0, 0, 0};
      bytes_seen = 0;
    end
    // Drop the byte leaving the window, weighted by the top power
    if (bytes_seen >= len) begin
      leaving = byte_ring[(ring_wr + WINDOW_MAX - len) % WINDOW_MAX];
      for (int l = 0; l < 3; l++) begin
        t      = (leaving * (longint'(top_pow[l]) % HASH_MOD[l])) % HASH_MOD[l];
        acc[l] = (HASH_MOD[l] + acc[l] - t) % HASH_MOD[l];
      end
    end
    for (int l = 0; l < 3; l++) begin
      acc[l] = (acc[l] * HASH_BASE[l] + longint'(b)) % HASH_MOD[l];
      h[l]   = acc[l][HASH_W-1:0];
    end
    byte_ring[ring_wr] = b;
    ring_wr = (ring_wr + 1) % WINDOW_MAX;
    if (bytes_seen < WINDOW_MAX) bytes_seen++;
    return bytes_seen >= len;
  endfunction

  // base^(n-1) mod m for one lane: the top power that matches window length n
  function automatic logic [HASH_W-1:0] lane_top_power(input int lane, input int n);
    longint unsigned p;
    p = 1;
    for (int k = 1; k < n; k++) p = (p * HASH_BASE[lane]) % HASH_MOD[lane];
    return p[HASH_W-1:0];
  endfunction

  function automatic void add_byte_row(input logic [BYTE_W-1:0] b, input logic r,
                                       input logic known = 1'b0, input int ha = 0,
                                       input int hb = 0, input int hc = 0);
    stim_row_t row;
    row            = '0;
    row.kind       = ROW_BYTE;
    row.data_byte  = b;
    row.restart    = r;
    row.known      = known;
    row.known_hash = {HASH_W'(hc), HASH_W'(hb), HASH_W'(ha)};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = v;
    plan.push_back(row);
  endfunction

  // Hold the byte channel low and wait until every awaited hash has come back;
  // with settle, also give the queue time to empty bytes that make no result
  task automatic drain_pipeline(input bit settle);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_hashes.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    streaming = 1'b0;
  endtask

  // One register write; cfg valid stays high so that writes in a group go back to back
  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    if (streaming) drain_pipeline(1'b1);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_WINDOW_LEN:  win_len_q  = v[LEN_W-1:0];
      REG_TOP_POWER_A: top_pow[0] = v[HASH_W-1:0];
      REG_TOP_POWER_B: top_pow[1] = v[HASH_W-1:0];
      REG_TOP_POWER_C: top_pow[2] = v[HASH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Send one byte after a random gap; at acceptance, record the hash triple it should make
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic r, input logic known,
                           input hash_trio_t known_hash);
    int         gap;
    bit         has_hash;
    hash_trio_t h;
    cfg_ch.valid <= 1'b0;
    streaming = 1'b1;
    gap = tx_gaps ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.in_byte <= b;
    item_ch.restart <= r;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    has_hash = advance_window_hash(b, r, h);
    if (has_hash) awaited_hashes.push_back(known ? known_hash : h);
    bytes_sent++;
  endtask

  // Watchdog: end the run if it stops making progress
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hash triples still awaited",
               cycles, awaited_hashes.size());
      $display("[rolling_triple_hash_window_unit] ERROR");
      $finish;
    end
  end

  // Result side: stall at random, then compare each hash triple with the oldest one awaited
  initial begin : hash_receiver
    int         stall;
    bit         bad;
    hash_trio_t got;
    hash_trio_t want;
    hash_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_stalls ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        hash_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hash_ch.ready <= 1'b1;
      @(posedge clk);
      while (!hash_ch.valid) @(posedge clk);
      got = {hash_ch.hash_c, hash_ch.hash_b, hash_ch.hash_a};
      hashes_checked++;
      if (awaited_hashes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected hash triple a=%0d b=%0d c=%0d at cycle %0d",
                   got[0], got[1], got[2], cycles);
      end else begin
        want = awaited_hashes.pop_front();
        bad  = 1'b0;
        for (int l = 0; l < 3; l++) if (got[l] !== want[l]) bad = 1'b1;
        if (bad) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("hash mismatch at cycle %0d: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                     cycles, want[0], want[1], want[2], got[0], got[1], got[2]);
        end
      end
    end
  end

  initial begin : stimulus
    int                    win;
    int                    eff;
    int                    pick;
    int                    n_str;
    int                    str_len;
    bit                    carry_on;
    logic                  r;
    logic [CFG_DATA_W-1:0] len_data;
    logic [CFG_DATA_W-1:0] pw;

    // Drive every input to a known value and mirror the reset state
    item_ch.valid   <= 1'b0;
    item_ch.in_byte <= '0;
    item_ch.restart <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_WINDOW_LEN;
    cfg_ch.data     <= '0;
    win_len_q  = 1;
    top_pow    = '{1, 1, 1};
    acc        = '{0, 0, 0};
    bytes_seen = 0;
    ring_wr    = 0;
    failures   = 0;
    cycles     = 0;
    tx_gaps    = 1'b1;
    rx_stalls  = 1'b1;
    streaming  = 1'b0;
    widest_window = 1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Reset leaves a one-byte window with unit top powers, so each
    // hash simply equals the byte just taken.
    add_byte_row(8'h00, 1'b1, 1'b1, 0, 0, 0);
    add_byte_row(8'hFF, 1'b0, 1'b1, 255, 255, 255);
    add_byte_row(8'h5A, 1'b0, 1'b1, 90, 90, 90);
    add_byte_row(8'hA5, 1'b1, 1'b1, 165, 165, 165);
    // Zero window length acts as one
    add_cfg_row(REG_WINDOW_LEN, '0);
    add_byte_row(8'h80, 1'b1, 1'b1, 128, 128, 128);
    add_byte_row(8'h01, 1'b0, 1'b1, 1, 1, 1);
    // Two-byte window with matching top powers: h = b0 * base + b1
    add_cfg_row(REG_WINDOW_LEN, 30'd2);
    add_cfg_row(REG_TOP_POWER_A, 30'd263);
    add_cfg_row(REG_TOP_POWER_B, 30'd269);
    add_cfg_row(REG_TOP_POWER_C, 30'd271);
    add_byte_row(8'h01, 1'b1);
    add_byte_row(8'h02, 1'b0, 1'b1, 265, 271, 273);
    add_byte_row(8'h03, 1'b0, 1'b1, 529, 541, 545);
    add_byte_row(8'hFF, 1'b0);
    // Restart in the middle of a string, then roll on
    add_byte_row(8'h09, 1'b1);
    add_byte_row(8'h00, 1'b0);
    // Top powers above their modulus get reduced before use
    add_cfg_row(REG_TOP_POWER_A, 30'h3FFF_FFFF);
    add_cfg_row(REG_TOP_POWER_B, 30'h3FFF_FFFF);
    add_cfg_row(REG_TOP_POWER_C, 30'h3FFF_FFFF);
    add_byte_row(8'hFF, 1'b0);
    add_byte_row(8'hFF, 1'b0);
    add_byte_row(8'h80, 1'b0);
    // Window length above the maximum acts as the maximum; change it mid-string
    add_cfg_row(REG_WINDOW_LEN, 30'h3FFF_FFFF);
    add_byte_row(8'h4D, 1'b0);
    add_byte_row(8'hC8, 1'b1);
    // Back to one byte with the reduced top powers still in place
    add_cfg_row(REG_WINDOW_LEN, 30'd1);
    add_byte_row(8'h21, 1'b0);
    add_byte_row(8'h7E, 1'b0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_register(plan[i].reg_idx, plan[i].value);
      else send_byte(plan[i].data_byte, plan[i].restart, plan[i].known, plan[i].known_hash);
    end

    // Random phases: pick a window setting, mostly with matching top powers, then
    // stream strings that mostly restart on their first byte and run past the window length
    phases = 0;
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      phases++;
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;

      pick = $urandom_range(0, 99);
      if (phases == 3)    win = WINDOW_MAX;
      else if (pick < 55) win = $urandom_range(1, 8);
      else if (pick < 85) win = $urandom_range(9, 48);
      else if (pick < 89) win = $urandom_range(49, WINDOW_MAX - 1);
      else if (pick < 93) win = 0;
      else if (pick < 96) win = $urandom_range(WINDOW_MAX + 1, (1 << LEN_W) - 1);
      else                win = WINDOW_MAX;
      eff = (win < 1) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;
      if (eff > widest_window) widest_window = eff;

      // Upper data bits are ignored for the window length; set them now and then
      len_data = CFG_DATA_W'(win);
      if ($urandom_range(0, 3) == 0)
        len_data[CFG_DATA_W-1:LEN_W] = (CFG_DATA_W - LEN_W)'($urandom);
      write_register(REG_WINDOW_LEN, len_data);
      for (int lane = 0; lane < 3; lane++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8)       pw = lane_top_power(lane, eff);
        else if (pick == 8) pw = 30'h3FFF_FFFF;
        else                pw = CFG_DATA_W'($urandom);
        write_register(cfg_reg_t'(int'(REG_TOP_POWER_A) + lane), pw);
      end

      // Now and then keep the old string going across the new window setting
      carry_on = $urandom_range(0, 4) == 0;
      n_str = (eff > 48) ? 1 : $urandom_range(1, 3);
      for (int s = 0; s < n_str; s++) begin
        // A few strings end no later than the window fills
        if ($urandom_range(0, 9) == 0) str_len = $urandom_range(1, eff);
        else str_len = eff + $urandom_range(1, (eff > 48) ? 40 : 30);
        for (int k = 0; k < str_len && rand_bytes < RAND_BYTES; k++) begin
          r = (k == 0 && !(s == 0 && carry_on)) || ($urandom_range(0, 99) == 0);
          send_byte(BYTE_W'($urandom_range(0, 255)), r, 1'b0, '0);
          rand_bytes++;
          // Occasionally hold the sender until every awaited hash is back
          if ($urandom_range(0, 149) == 0) drain_pipeline(1'b0);
        end
      end
    end

    drain_pipeline(1'b1);

    $display("sent %0d bytes over %0d random window settings (%0d register writes, widest %0d)",
             bytes_sent, phases, reg_writes, widest_window);
    $display("compared %0d hash triples, %0d failures", hashes_checked, failures);
    if (failures == 0 && awaited_hashes.size() == 0) begin
      $display("[rolling_triple_hash_window_unit] OK");
    end else begin
      $display("[rolling_triple_hash_window_unit] ERROR");
    end
    $finish;
  end

endmodule
